// ===== sv/stream_find_replace_unit_defines.svh =====
// ----------------------------------------------------------------------------
// stream find/replace assertion macros
// shared concurrent assertion forms, clocked on clk, disabled during reset
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_UNIT_DEFINES_SVH
`define STREAM_FIND_REPLACE_UNIT_DEFINES_SVH

// same-cycle implication
`define SFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// types and constants of the stream find/replace unit
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    // characters that fit in one 64-bit pattern or replacement register
    localparam int WORD_CHARS  = CFG_DATA_W / CHAR_W;

    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 2'd0,
        REG_PATTERN_LENGTH     = 2'd1,
        REG_REPLACEMENT_BYTES  = 2'd2,
        REG_REPLACEMENT_LENGTH = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_last;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } out_item_t;

endpackage

`default_nettype wire

// ===== sv/stream_find_replace_unit.sv =====
// ----------------------------------------------------------------------------
// stream_find_replace_unit
// streaming substring find and replace with a lookahead window
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in      | input     | in_valid / in_ready | in_data  (char, last)
//  out     | output    | out_valid/out_ready | out_data (char, last)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
//  - one item per cycle while each item yields at most one result and the
//    output is not stalled; an item yielding n results holds the result buffer
//    until all n have left the output shift register, one per cycle with out_ready
//  - the input register takes one more item while results wait downstream
//  - reset clears counts and control registers at once, no clearing pass
//
`default_nettype none

`include "stream_find_replace_unit_defines.svh"

module stream_find_replace_unit #(
    parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire sfr_pkg::in_item_t               in_data,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output sfr_pkg::out_item_t                   out_data,

    input  wire logic                            cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = sfr_pkg::CHAR_W;
    localparam int LW = sfr_pkg::LEN_W;

    // lengths saturate at the parameter maximum, capped at the register width of eight characters
    localparam int WIN_DEPTH = (MAX_PATTERN > sfr_pkg::WORD_CHARS) ?
                               sfr_pkg::WORD_CHARS : MAX_PATTERN;
    localparam int REP_DEPTH = (MAX_REPLACEMENT > sfr_pkg::WORD_CHARS) ?
                               sfr_pkg::WORD_CHARS : MAX_REPLACEMENT;
    localparam int BUF_DEPTH = (WIN_DEPTH > REP_DEPTH) ? WIN_DEPTH : REP_DEPTH;
    localparam int WCNT_W    = $clog2(WIN_DEPTH + 1);
    localparam int RCNT_W    = $clog2(REP_DEPTH + 1);
    localparam int BCNT_W    = $clog2(BUF_DEPTH + 1);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [sfr_pkg::CFG_DATA_W-1:0] pat_bytes_reg;
    logic [LW-1:0]                  pat_len_reg;
    logic [sfr_pkg::CFG_DATA_W-1:0] rep_bytes_reg;
    logic [LW-1:0]                  rep_len_reg;
    logic                           pat_len_wr;

    // ------------------------------------------------------------------
    // input register, window and result buffer
    // ------------------------------------------------------------------
    logic                 in_valid_reg;
    sfr_pkg::in_item_t    in_item_reg;

    logic [CW-1:0]        win_reg  [WIN_DEPTH];
    logic [CW-1:0]        win_next [WIN_DEPTH];
    logic [WCNT_W-1:0]    wcnt_reg;
    logic [WCNT_W-1:0]    wcnt_next;

    logic [CW-1:0]        buf_reg  [BUF_DEPTH];
    logic [CW-1:0]        buf_next [BUF_DEPTH];
    logic [BCNT_W-1:0]    buf_cnt_reg;
    logic [BCNT_W-1:0]    buf_cnt_next;
    logic                 buf_last_reg;
    logic                 buf_last_next;

    logic                 buf_free;
    logic                 process_fire;
    logic                 drain;

    // per-item datapath
    logic [WCNT_W-1:0]    plen;
    logic [RCNT_W-1:0]    rlen;
    logic [WCNT_W-1:0]    base;
    logic [WCNT_W-1:0]    cnt2;
    logic [CW-1:0]        w2 [WIN_DEPTH];
    logic [WIN_DEPTH-1:0] match;
    logic                 full;
    logic                 hit;
    logic [CW-1:0]        res [BUF_DEPTH];
    logic [BCNT_W-1:0]    ld_n;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign drain        = out_valid && out_ready;
    // buffer empty or handing over its final result this cycle
    assign buf_free     = (buf_cnt_reg == '0) || (buf_cnt_reg == BCNT_W'(1) && out_ready);
    assign process_fire = in_valid_reg && buf_free;
    assign in_ready     = !in_valid_reg || buf_free;

    assign out_valid         = (buf_cnt_reg != '0);
    assign out_data.out_char = buf_reg[0];
    assign out_data.out_last = buf_last_reg && (buf_cnt_reg == BCNT_W'(1));

    assign pat_len_wr = cfg_we && (sfr_pkg::cfg_reg_t'(cfg_index) == sfr_pkg::REG_PATTERN_LENGTH);

    // ------------------------------------------------------------------
    // match logic: one item against window plus pattern
    // ------------------------------------------------------------------
    always_comb
    begin
        plen = (pat_len_reg > LW'(WIN_DEPTH)) ? WCNT_W'(WIN_DEPTH) : WCNT_W'(pat_len_reg);
        rlen = (rep_len_reg > LW'(REP_DEPTH)) ? RCNT_W'(REP_DEPTH) : RCNT_W'(rep_len_reg);

        // restart the window if it somehow already holds a full pattern
        base = (wcnt_reg >= plen) ? '0 : wcnt_reg;
        cnt2 = base + WCNT_W'(1);

        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            w2[i]    = (WCNT_W'(i) == base) ? in_item_reg.in_char : win_reg[i];
            match[i] = (w2[i] == pat_bytes_reg[i*CW +: CW]) || (WCNT_W'(i) >= plen);
        end
        full = (cnt2 == plen);
        hit  = &match;
    end

    always_comb
    begin
        for (int j = 0; j < BUF_DEPTH; j++)
        begin
            res[j] = '0;
        end
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            win_next[i] = w2[i];
        end
        ld_n      = '0;
        wcnt_next = cnt2;

        priority if (plen == '0)
        begin
            // pass-through
            res[0]    = in_item_reg.in_char;
            ld_n      = BCNT_W'(1);
            wcnt_next = '0;
        end
        else if (full && hit)
        begin
            for (int j = 0; j < BUF_DEPTH; j++)
            begin
                if (j < REP_DEPTH)
                begin
                    res[j] = rep_bytes_reg[j*CW +: CW];
                end
            end
            ld_n      = BCNT_W'(rlen);
            wcnt_next = '0;
        end
        else if (in_item_reg.in_last)
        begin
            // flush: a miss emits the head, then the rest, so the window in order
            for (int j = 0; j < BUF_DEPTH; j++)
            begin
                if (j < WIN_DEPTH)
                begin
                    res[j] = w2[j];
                end
            end
            ld_n      = BCNT_W'(cnt2);
            wcnt_next = '0;
        end
        else if (full)
        begin
            // miss: emit the head and slide by one
            res[0] = w2[0];
            ld_n   = BCNT_W'(1);
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                if (i + 1 < WIN_DEPTH)
                begin
                    win_next[i] = w2[i+1];
                end
            end
            wcnt_next = plen - WCNT_W'(1);
        end
        else
        begin
            ld_n      = '0;
            wcnt_next = cnt2;
        end
    end

    // ------------------------------------------------------------------
    // result buffer: load on a processed item, shift on each drain
    // ------------------------------------------------------------------
    always_comb
    begin
        buf_cnt_next  = buf_cnt_reg;
        buf_last_next = buf_last_reg;
        for (int j = 0; j < BUF_DEPTH; j++)
        begin
            buf_next[j] = buf_reg[j];
        end

        if (process_fire)
        begin
            for (int j = 0; j < BUF_DEPTH; j++)
            begin
                buf_next[j] = res[j];
            end
            buf_cnt_next  = ld_n;
            buf_last_next = in_item_reg.in_last;
        end
        else if (drain)
        begin
            for (int j = 0; j < BUF_DEPTH; j++)
            begin
                if (j + 1 < BUF_DEPTH)
                begin
                    buf_next[j] = buf_reg[j+1];
                end
            end
            buf_cnt_next = buf_cnt_reg - BCNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            in_valid_reg  <= 1'b0;
            wcnt_reg      <= '0;
            buf_cnt_reg   <= '0;
            buf_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (sfr_pkg::cfg_reg_t'(cfg_index))
                    sfr_pkg::REG_PATTERN_BYTES:      pat_bytes_reg <= cfg_data;
                    sfr_pkg::REG_PATTERN_LENGTH:     pat_len_reg   <= cfg_data[LW-1:0];
                    sfr_pkg::REG_REPLACEMENT_BYTES:  rep_bytes_reg <= cfg_data;
                    sfr_pkg::REG_REPLACEMENT_LENGTH: rep_len_reg   <= cfg_data[LW-1:0];
                endcase
            end

            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            // a new pattern length drops whatever the window holds
            if (pat_len_wr)
            begin
                wcnt_reg <= '0;
            end
            else if (process_fire)
            begin
                wcnt_reg <= wcnt_next;
            end

            buf_cnt_reg  <= buf_cnt_next;
            buf_last_reg <= buf_last_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
        if (process_fire)
        begin
            for (int i = 0; i < WIN_DEPTH; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
        for (int j = 0; j < BUF_DEPTH; j++)
        begin
            buf_reg[j] <= buf_next[j];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SFR_ASSERT_NEXT(a_load_count, process_fire && ld_n != '0,
        out_valid && buf_cnt_reg == $past(ld_n), "result buffer load count wrong")
    `SFR_ASSERT_NEXT(a_in_capture, in_valid && in_ready,
        in_valid_reg, "accepted item not held in input register")
    `SFR_ASSERT_NEXT(a_last_clears, process_fire && in_item_reg.in_last,
        wcnt_reg == '0, "window not cleared after last character")
    `SFR_ASSERT_NEXT(a_drain_empty, drain && buf_cnt_reg == BCNT_W'(1) && !process_fire,
        !out_valid, "result buffer not empty after final drain")
    `SFR_ASSERT_SAME(a_no_overlap, process_fire && buf_cnt_reg > BCNT_W'(1),
        1'b0, "item processed over pending results")

endmodule

`default_nettype wire
